// ===== rtl/delta_timer_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Delta timer queue assertion macros
// Shared macros for the concurrent checks in the timer queue core.
// ----------------------------------------------------------------------------
`ifndef DELTA_TIMER_QUEUE_CORE_DEFINES_SVH
`define DELTA_TIMER_QUEUE_CORE_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define DTQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta timer queue package
// Command and status codes, state codes, beat types, the stored entry and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIRE   = 2'd2,
        CMD_ELAPSE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } st_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  function_id;
        logic [30:0] delay_ms;
        logic [30:0] elapsed_ms;
    } dtq_req_t;

    typedef struct packed {
        logic        fired;
        logic [7:0]  fired_id;
        logic [30:0] wait_ms;
        status_t     status;
        logic [4:0]  removed_count;
    } dtq_rsp_t;

    typedef struct packed {
        logic signed [31:0] delay;
        logic [7:0]         id;
    } entry_t;

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [32:0] b);
        logic signed [33:0] d;
        d = $signed({{2{a[31]}}, a}) - $signed({b[32], b});
        if (d[33:31] == 3'b000 || d[33:31] == 3'b111) begin
            return d[31:0];
        end else if (d[33]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

// ===== rtl/dtq_mem.sv =====
// ----------------------------------------------------------------------------
// Delta timer queue entry memory
// Entry store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtq_mem
    import dtq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/delta_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// Delta timer queue core
// Timer entries ordered by signed delay, held in one entry memory.
// ----------------------------------------------------------------------------
// Usage: a command beat (req) is taken at a clock edge with start high and
// busy low. Add inserts an entry behind those of equal delay, remove drops
// every entry of an id, fire pops the head and subtracts its delay from the
// rest, elapse subtracts a measured time from every entry. Delays saturate
// at the signed 32-bit limits.
// Each command gives exactly one result beat on rsp, marked by done for a
// single cycle; the receiver always takes it and cannot stall the block.
// The walk visits the queued entries in turn, so a command can last longer
// the more entries are queued. An add that finds its place early, a command
// on an empty queue, a full add and an empty fire finish sooner. The duration
// is set by the walk over the entry memory, one read a cycle through its
// single read port. Busy falls at the edge that ends the result beat, and
// the next command can be taken once busy is low.
// Reset empties the queue at once through the occupancy count; the memory
// itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "delta_timer_queue_core_defines.svh"

module delta_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dtq_req_t req,
    output logic     busy,
    output logic     done,
    output dtq_rsp_t rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    st_t                state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [7:0]         fid_reg, fid_next;
    logic [30:0]        dly_reg, dly_next;
    logic [30:0]        elapsed_reg, elapsed_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      left_reg, left_next;
    logic [CW-1:0]      w_reg, w_next;
    logic [CW-1:0]      removed_reg, removed_next;
    logic [AW-1:0]      didx_reg, didx_next;
    logic               dv_reg, dv_next;
    logic               placed_reg, placed_next;
    logic               fired_reg, fired_next;
    logic [7:0]         fired_id_reg, fired_id_next;
    logic signed [31:0] head_reg, head_next;
    status_t            status_reg, status_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    entry_t             mem_rdata;

    logic signed [32:0] amount;
    logic signed [31:0] sub_delay;
    entry_t             new_entry;
    logic [31:0]        removed_wide;

    dtq_mem #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign amount    = (cmd_reg == CMD_FIRE) ? {head_reg[31], head_reg}
                                             : {2'b00, elapsed_reg};
    assign sub_delay = sat_sub(mem_rdata.delay, amount);
    assign new_entry = '{delay: $signed({1'b0, dly_reg}), id: fid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        fid_reg      <= fid_next;
        dly_reg      <= dly_next;
        elapsed_reg  <= elapsed_next;
        ptr_reg      <= ptr_next;
        w_reg        <= w_next;
        removed_reg  <= removed_next;
        didx_reg     <= didx_next;
        placed_reg   <= placed_next;
        fired_reg    <= fired_next;
        fired_id_reg <= fired_id_next;
        head_reg     <= head_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        fid_next      = fid_reg;
        dly_next      = dly_reg;
        elapsed_next  = elapsed_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        w_next        = w_reg;
        removed_next  = removed_reg;
        didx_next     = didx_reg;
        dv_next       = 1'b0;
        placed_next   = placed_reg;
        fired_next    = fired_reg;
        fired_id_next = fired_id_reg;
        head_next     = head_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = new_entry;
        mem_re        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = req.cmd;
                    fid_next     = req.function_id;
                    dly_next     = req.delay_ms;
                    elapsed_next = req.elapsed_ms;
                    left_next    = count_reg;
                    w_next       = '0;
                    removed_next = '0;
                    placed_next  = 1'b0;
                    fired_next   = 1'b0;
                    status_next  = STATUS_OK;
                    ptr_next     = (req.cmd == CMD_ADD) ? count_reg - CW'(1) : '0;
                    state_next   = ST_WALK;
                    if (req.cmd == CMD_ADD && count_reg == CW'(SLOTS))
                    begin
                        status_next = STATUS_FULL;
                        state_next  = ST_RESP;
                    end
                    else if (req.cmd == CMD_FIRE && count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                        state_next  = ST_RESP;
                    end
                    else if (req.cmd == CMD_FIRE)
                    begin
                        fired_next = 1'b1;
                    end
                end
            end

            ST_WALK:
            begin
                if (left_reg != '0 && !placed_reg)
                begin
                    mem_re    = 1'b1;
                    dv_next   = 1'b1;
                    didx_next = ptr_reg[AW-1:0];
                    left_next = left_reg - CW'(1);
                    ptr_next  = (cmd_reg == CMD_ADD) ? ptr_reg - CW'(1)
                                                     : ptr_reg + CW'(1);
                end

                if (dv_reg)
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (!placed_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = didx_reg + AW'(1);
                                if (mem_rdata.delay > new_entry.delay)
                                begin
                                    mem_wdata = mem_rdata;
                                end
                                else
                                begin
                                    mem_wdata   = new_entry;
                                    placed_next = 1'b1;
                                    left_next   = '0;
                                end
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (mem_rdata.id == fid_reg)
                            begin
                                removed_next = removed_reg + CW'(1);
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = w_reg[AW-1:0];
                                mem_wdata = mem_rdata;
                                w_next    = w_reg + CW'(1);
                            end
                        end
                        CMD_FIRE:
                        begin
                            if (didx_reg == '0)
                            begin
                                head_next     = mem_rdata.delay;
                                fired_id_next = mem_rdata.id;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = didx_reg - AW'(1);
                                mem_wdata = '{delay: sub_delay, id: mem_rdata.id};
                            end
                        end
                        default:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = didx_reg;
                            mem_wdata = '{delay: sub_delay, id: mem_rdata.id};
                        end
                    endcase
                end

                if (left_reg == '0 && !dv_reg)
                begin
                    state_next = ST_RESP;
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (!placed_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = new_entry;
                            end
                            count_next = count_reg + CW'(1);
                        end
                        CMD_REMOVE:
                        begin
                            count_next = w_reg;
                        end
                        CMD_FIRE:
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end

            ST_RESP:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign removed_wide = 32'(removed_reg);

    always_comb
    begin
        busy              = (state_reg != ST_IDLE);
        done              = (state_reg == ST_RESP);
        rsp.fired         = fired_reg;
        rsp.fired_id      = fired_reg ? fired_id_reg : 8'd0;
        rsp.wait_ms       = (fired_reg && head_reg > 32'sd0) ? head_reg[30:0] : 31'd0;
        rsp.status        = status_reg;
        rsp.removed_count = (cmd_reg == CMD_REMOVE) ? removed_wide[4:0] : 5'd0;
    end

    `DTQ_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
    `DTQ_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CW'(SLOTS), "occupancy beyond pool size")
    `DTQ_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `DTQ_ASSERT_SAME(a_fired_ok, done && rsp.fired, rsp.status == STATUS_OK, "fired with bad status")

endmodule

// ===== sim/delta_timer_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// Delta timer queue core testbench
// Drives add, remove, fire and elapse command beats into the timer queue with
// random bursts and gaps, predicts every result beat from a queue model of
// its own, and compares each result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import dtq_pkg::*;

class dtq_scoreboard;
    localparam longint DELAY_MAX = 64'sd2147483647;
    localparam longint DELAY_MIN = -64'sd2147483648;

    int         capacity;
    int         errors;
    int         delay_q[$];
    logic [7:0] id_q[$];
    dtq_rsp_t   expected_q[$];

    function new(int slots);
        capacity = slots;
        errors = 0;
    endfunction

    function int clamp_sub(int a, longint b);
        longint r;
        r = longint'(a) - b;
        if (r > DELAY_MAX)
        begin
            r = DELAY_MAX;
        end
        if (r < DELAY_MIN)
        begin
            r = DELAY_MIN;
        end
        return int'(r);
    endfunction

    function void shift_all(longint amount);
        foreach (delay_q[i])
        begin
            delay_q[i] = clamp_sub(delay_q[i], amount);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_request(dtq_req_t r);
        dtq_rsp_t   res;
        int         pos;
        int         head;
        int         removed;
        int         kept_delay[$];
        logic [7:0] kept_id[$];
        res = '0;
        res.status = STATUS_OK;
        case (r.cmd)
            CMD_ADD:
            begin
                if (delay_q.size() >= capacity)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < delay_q.size() && delay_q[pos] <= int'(r.delay_ms))
                    begin
                        pos++;
                    end
                    delay_q.insert(pos, int'(r.delay_ms));
                    id_q.insert(pos, r.function_id);
                end
            end
            CMD_REMOVE:
            begin
                removed = 0;
                foreach (id_q[i])
                begin
                    if (id_q[i] == r.function_id)
                    begin
                        removed++;
                    end
                    else
                    begin
                        kept_delay.push_back(delay_q[i]);
                        kept_id.push_back(id_q[i]);
                    end
                end
                delay_q = kept_delay;
                id_q = kept_id;
                res.removed_count = 5'(removed);
            end
            CMD_FIRE:
            begin
                if (delay_q.size() == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else
                begin
                    head = delay_q[0];
                    res.fired = 1'b1;
                    res.fired_id = id_q[0];
                    res.wait_ms = (head > 0) ? 31'(head) : 31'd0;
                    shift_all(longint'(head));
                    void'(delay_q.pop_front());
                    void'(id_q.pop_front());
                end
            end
            default:
            begin
                shift_all(longint'(r.elapsed_ms));
            end
        endcase
        expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(dtq_rsp_t got);
        dtq_rsp_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: result beat with no command pending, expected none, actual %0h",
                     $time, got);
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("fired", want.fired, got.fired);
            compare_field("fired_id", want.fired_id, got.fired_id);
            compare_field("wait_ms", want.wait_ms, got.wait_ms);
            compare_field("status", want.status, got.status);
            compare_field("removed_count", want.removed_count, got.removed_count);
        end
    endfunction
endclass

module delta_timer_queue_core_tb;
    localparam int          SLOTS        = 16;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          TAIL_CYCLES  = SLOTS + 8;
    localparam int          RANDOM_BEATS = 450;
    localparam logic [30:0] DELAY_TOP    = 31'h7FFF_FFFF;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    dtq_req_t      req = '0;
    logic          busy;
    logic          done;
    dtq_rsp_t      rsp;
    dtq_scoreboard board;
    int            cycle_count = 0;
    int            burst_left = 1;
    bit            fill_phase = 1'b1;

    delta_timer_queue_core #(
        .SLOTS(SLOTS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .busy (busy),
        .done (done),
        .rsp  (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            board.check_result(rsp);
        end
    end

    task automatic send_cmd(input cmd_t c, input logic [7:0] id,
                            input logic [30:0] dly, input logic [30:0] el);
        dtq_req_t r;
        r.cmd = c;
        r.function_id = id;
        r.delay_ms = dly;
        r.elapsed_ms = el;
        req <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        board.note_request(r);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic pace();
        burst_left--;
        if (burst_left <= 0)
        begin
            hold_off($urandom_range(1, 30));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    task automatic issue(input cmd_t c, input logic [7:0] id,
                         input logic [30:0] dly, input logic [30:0] el);
        send_cmd(c, id, dly, el);
        pace();
    endtask

    function automatic logic [7:0] draw_id();
        if ($urandom_range(0, 9) < 2)
        begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, 5));
    endfunction

    function automatic logic [30:0] draw_delay();
        case ($urandom_range(0, 9))
            0: return 31'd0;
            1: return DELAY_TOP;
            2, 3: return 31'($urandom);
            4, 5: return 31'(100 * $urandom_range(0, 5));
            default: return 31'($urandom_range(0, 5000));
        endcase
    endfunction

    function automatic logic [30:0] draw_elapsed();
        case ($urandom_range(0, 9))
            0: return DELAY_TOP;
            1: return 31'($urandom);
            2: return 31'd0;
            default: return 31'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic cmd_t draw_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (fill_phase)
        begin
            if (r < 60) return CMD_ADD;
            if (r < 70) return CMD_REMOVE;
            if (r < 85) return CMD_FIRE;
            return CMD_ELAPSE;
        end
        if (r < 20) return CMD_ADD;
        if (r < 35) return CMD_REMOVE;
        if (r < 80) return CMD_FIRE;
        return CMD_ELAPSE;
    endfunction

    initial
    begin
        int          i;
        logic [30:0] fill_delay;
        board = new(SLOTS);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: fire, elapse and a remove of an absent id.
        issue(CMD_FIRE, 8'h00, 31'd0, 31'd0);
        issue(CMD_ELAPSE, 8'hFF, DELAY_TOP, DELAY_TOP);
        issue(CMD_REMOVE, 8'hFF, 31'd0, 31'd0);

        // Fill the pool with ties among the delays, overflow it, then empty it by id.
        for (i = 0; i < SLOTS; i++)
        begin
            case (i % 4)
                0: fill_delay = 31'd0;
                1: fill_delay = DELAY_TOP;
                2: fill_delay = 31'h5555_5555;
                default: fill_delay = 31'h2AAA_AAAA;
            endcase
            issue(CMD_ADD, 8'h3C, fill_delay, ~fill_delay);
        end
        issue(CMD_ADD, 8'hC3, 31'd7, 31'd0);
        issue(CMD_REMOVE, 8'h3C, DELAY_TOP, 31'd0);

        // Drive one delay down to the negative limit, then fire so the rest saturates up.
        issue(CMD_ADD, 8'h00, 31'd0, 31'd0);
        issue(CMD_ELAPSE, 8'h00, 31'd0, DELAY_TOP);
        issue(CMD_ELAPSE, 8'h00, 31'd0, DELAY_TOP);
        issue(CMD_ADD, 8'hFF, DELAY_TOP, 31'd0);
        issue(CMD_FIRE, 8'h00, 31'd0, 31'd0);
        send_cmd(CMD_FIRE, 8'h00, 31'd0, 31'd0);
        wait_drain();

        for (i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 40 == 0)
            begin
                fill_phase = ($urandom_range(0, 1) == 1);
            end
            send_cmd(draw_cmd(), draw_id(), draw_delay(), draw_elapsed());
            if (i % 100 == 99 || i == RANDOM_BEATS - 1)
            begin
                wait_drain();
            end
            else
            begin
                pace();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_mem.sv
rtl/delta_timer_queue_core.sv
sim/delta_timer_queue_core_tb.sv
